### rtl/mtt_pkg.sv
package mtt_pkg;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STOP  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_STOP   = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_EXPIRY = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [31:0] ID_NONE     = 32'd0;
    localparam logic [31:0] ID_RESERVED = 32'd1;

    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 4;

    typedef enum logic [1:0] {
        OP_START,
        OP_STOP,
        OP_QUERY,
        OP_TICK
    } t_op;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_SCAN,
        BS_FIN,
        BS_LAST
    } t_bst;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] duration_ms;
        logic [31:0] timer_id;
        logic [15:0] client_handle;
        logic [31:0] client_param;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [31:0] result_id;
        logic        running;
        logic [31:0] remaining_ms;
        logic [15:0] owner_handle;
        logic [31:0] owner_param;
        logic        last;
    } t_rsp;

    typedef struct packed {
        t_op  op;
        t_req req;
    } t_qent;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_qctl;

endpackage

### rtl/multiplexed_timer_table.sv
// Channel   | Handshake                      | Payload
// ----------+--------------------------------+----------------------
// request   | start in, busy out             | i_req (mtt_pkg::t_req)
// result    | o_rsp_valid out, one cycle     | o_rsp (mtt_pkg::t_rsp)
//
// A request waits in a two-entry queue; busy is high while the queue is full.
// Each scan reads the slot table one entry per cycle, so a start, stop or query
// takes one scan, and a tick takes one scan per expiring timer plus a final scan
// when fewer than 16 expire, at most 16 scans.
// Reset is synchronous; it empties the table and sets time to zero.
// Results cannot be held off by the receiver.
module multiplexed_timer_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int TIME_BITS     = 48
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  mtt_pkg::t_req  i_req,
    output logic           o_rsp_valid,
    output mtt_pkg::t_rsp  o_rsp
);

    mtt_pkg::t_qent q;
    mtt_pkg::t_qctl qctl;

    mtt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req     (i_req),
        .o_busy    (busy),
        .o_q       (q),
        .i_pop     (qctl.pop),
        .o_q_valid (qctl.valid)
    );

    mtt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TIME_BITS     (TIME_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q),
        .i_q_valid   (qctl.valid),
        .o_pop       (qctl.pop),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule

### rtl/mtt_front.sv
module mtt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  mtt_pkg::t_req      i_req,
    output logic               o_busy,
    output mtt_pkg::t_qent     o_q,
    input  logic               i_pop,
    output logic               o_q_valid
);

    mtt_pkg::t_qent r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           n_wp;
    logic           n_rp;
    logic [1:0]     n_cnt;
    logic           push;
    logic           pop;
    mtt_pkg::t_op   op;

    always_comb begin
        case (i_req.action)
            mtt_pkg::ACT_START: op = mtt_pkg::OP_START;
            mtt_pkg::ACT_STOP:  op = mtt_pkg::OP_STOP;
            mtt_pkg::ACT_QUERY: op = mtt_pkg::OP_QUERY;
            default:            op = mtt_pkg::OP_TICK;
        endcase
    end

    assign o_busy    = (r_cnt == 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q       = r_mem[r_rp];
    assign push      = i_start && !o_busy;
    assign pop       = i_pop && o_q_valid;

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{op: op, req: i_req};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

### rtl/mtt_back.sv
module mtt_back #(
    parameter int TABLE_ENTRIES = 16,
    parameter int TIME_BITS     = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mtt_pkg::t_qent     i_q,
    input  logic               i_q_valid,
    output logic               o_pop,
    output logic               o_rsp_valid,
    output mtt_pkg::t_rsp      o_rsp
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = IW + 1;
    localparam int TB = TIME_BITS;

    logic [31:0]   m_id  [TABLE_ENTRIES];
    logic [TB-1:0] m_exp [TABLE_ENTRIES];
    logic [15:0]   m_hnd [TABLE_ENTRIES];
    logic [31:0]   m_prm [TABLE_ENTRIES];

    logic [31:0]   r_rd_id;
    logic [TB-1:0] r_rd_exp;
    logic [15:0]   r_rd_hnd;
    logic [31:0]   r_rd_prm;

    mtt_pkg::t_bst r_state, n_state;
    mtt_pkg::t_qent r_cmd, n_cmd;
    logic [TB-1:0] r_now, n_now;
    logic [31:0]   r_idc, n_idc;
    logic [TABLE_ENTRIES-1:0] r_vld, n_vld;
    logic [CW-1:0] r_addr, n_addr;
    logic          r_rv, n_rv;
    logic [IW-1:0] r_ridx, n_ridx;
    logic          r_found, n_found;
    logic [IW-1:0] r_best, n_best;
    logic [TB-1:0] r_blate, n_blate;
    logic [31:0]   r_bid, n_bid;
    logic [TB-1:0] r_bexp, n_bexp;
    logic [15:0]   r_bhnd, n_bhnd;
    logic [31:0]   r_bprm, n_bprm;
    logic [mtt_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic          r_have, n_have;
    mtt_pkg::t_rsp r_pend, n_pend;
    logic          r_out_valid, n_out_valid;
    mtt_pkg::t_rsp r_out, n_out;

    logic          w_en;
    logic [TB-1:0] ahead_s;
    logic [TB-1:0] late_s;
    logic          due_s;
    logic [TB-1:0] ahead_b;
    logic          due_b;
    logic          hit;
    logic [31:0]   id_inc;

    assign ahead_s = r_rd_exp - r_now;
    assign late_s  = r_now - r_rd_exp;
    assign due_s   = (ahead_s == '0) || (ahead_s[TB-1:32] != '0);
    assign ahead_b = r_bexp - r_now;
    assign due_b   = (ahead_b == '0) || (ahead_b[TB-1:32] != '0);
    assign id_inc  = r_idc + 32'd1;

    always_comb begin
        case (r_cmd.op)
            mtt_pkg::OP_START: hit = !r_vld[r_ridx] && !r_found;
            mtt_pkg::OP_STOP,
            mtt_pkg::OP_QUERY: hit = r_vld[r_ridx] && !r_found
                                     && (r_rd_id == r_cmd.req.timer_id);
            default:           hit = r_vld[r_ridx] && due_s
                                     && (!r_found || (late_s > r_blate));
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_now       = r_now;
        n_idc       = r_idc;
        n_vld       = r_vld;
        n_addr      = r_addr;
        n_rv        = 1'b0;
        n_ridx      = r_addr[IW-1:0];
        n_found     = r_found;
        n_best      = r_best;
        n_blate     = r_blate;
        n_bid       = r_bid;
        n_bexp      = r_bexp;
        n_bhnd      = r_bhnd;
        n_bprm      = r_bprm;
        n_cnt       = r_cnt;
        n_have      = r_have;
        n_pend      = r_pend;
        n_out_valid = 1'b0;
        n_out       = r_out;
        w_en        = 1'b0;
        o_pop       = 1'b0;
        case (r_state)
            mtt_pkg::BS_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_q;
                    n_addr  = '0;
                    n_found = 1'b0;
                    n_state = mtt_pkg::BS_SCAN;
                    if (i_q.op == mtt_pkg::OP_TICK) begin
                        n_now  = r_now + TB'(1);
                        n_cnt  = '0;
                        n_have = 1'b0;
                    end
                    if (i_q.op == mtt_pkg::OP_START) begin
                        if (id_inc == mtt_pkg::ID_NONE || id_inc == mtt_pkg::ID_RESERVED) begin
                            n_idc = mtt_pkg::ID_RESERVED + 32'd1;
                        end else begin
                            n_idc = id_inc;
                        end
                    end
                end
            end
            mtt_pkg::BS_SCAN: begin
                if (r_addr != CW'(TABLE_ENTRIES)) begin
                    n_rv   = 1'b1;
                    n_addr = r_addr + CW'(1);
                end
                if (r_rv && hit) begin
                    n_found = 1'b1;
                    n_best  = r_ridx;
                    n_blate = late_s;
                    n_bid   = r_rd_id;
                    n_bexp  = r_rd_exp;
                    n_bhnd  = r_rd_hnd;
                    n_bprm  = r_rd_prm;
                end
                if (r_addr == CW'(TABLE_ENTRIES) && !r_rv) begin
                    n_state = mtt_pkg::BS_FIN;
                end
            end
            mtt_pkg::BS_FIN: begin
                n_out      = '0;
                n_out.last = 1'b1;
                n_state    = mtt_pkg::BS_IDLE;
                case (r_cmd.op)
                    mtt_pkg::OP_START: begin
                        n_out_valid = 1'b1;
                        n_out.kind  = mtt_pkg::KIND_START;
                        if (r_found) begin
                            w_en            = 1'b1;
                            n_vld[r_best]   = 1'b1;
                            n_out.status    = mtt_pkg::ST_OK;
                            n_out.result_id = r_idc;
                        end else begin
                            n_out.status = mtt_pkg::ST_FULL;
                        end
                    end
                    mtt_pkg::OP_STOP: begin
                        n_out_valid     = 1'b1;
                        n_out.kind      = mtt_pkg::KIND_STOP;
                        n_out.result_id = r_cmd.req.timer_id;
                        n_out.status    = r_found ? mtt_pkg::ST_OK : mtt_pkg::ST_NOT_FOUND;
                        if (r_found) begin
                            n_vld[r_best] = 1'b0;
                        end
                    end
                    mtt_pkg::OP_QUERY: begin
                        n_out_valid     = 1'b1;
                        n_out.kind      = mtt_pkg::KIND_QUERY;
                        n_out.result_id = r_cmd.req.timer_id;
                        n_out.status    = r_found ? mtt_pkg::ST_OK : mtt_pkg::ST_NOT_FOUND;
                        n_out.running   = r_found;
                        if (r_found && !due_b) begin
                            n_out.remaining_ms = ahead_b[31:0];
                        end
                    end
                    default: begin
                        if (r_found) begin
                            n_vld[r_best] = 1'b0;
                            if (r_have) begin
                                n_out_valid = 1'b1;
                                n_out       = r_pend;
                                n_out.last  = 1'b0;
                            end
                            n_pend              = '0;
                            n_pend.kind         = mtt_pkg::KIND_EXPIRY;
                            n_pend.status       = mtt_pkg::ST_OK;
                            n_pend.result_id    = r_bid;
                            n_pend.owner_handle = r_bhnd;
                            n_pend.owner_param  = r_bprm;
                            n_have              = 1'b1;
                            n_cnt               = r_cnt + mtt_pkg::CNT_W'(1);
                            if (r_cnt == mtt_pkg::CNT_W'(mtt_pkg::MAX_RESULTS - 1)) begin
                                n_state = mtt_pkg::BS_LAST;
                            end else begin
                                n_state = mtt_pkg::BS_SCAN;
                                n_addr  = '0;
                                n_found = 1'b0;
                            end
                        end else if (r_have) begin
                            n_out_valid = 1'b1;
                            n_out       = r_pend;
                            n_out.last  = 1'b1;
                        end
                    end
                endcase
            end
            mtt_pkg::BS_LAST: begin
                n_out_valid = 1'b1;
                n_out       = r_pend;
                n_out.last  = 1'b1;
                n_state     = mtt_pkg::BS_IDLE;
            end
            default: begin
                n_state = mtt_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_id[r_best]  <= r_idc;
            m_exp[r_best] <= r_now + TB'(r_cmd.req.duration_ms);
            m_hnd[r_best] <= r_cmd.req.client_handle;
            m_prm[r_best] <= r_cmd.req.client_param;
        end
        r_rd_id  <= m_id[r_addr[IW-1:0]];
        r_rd_exp <= m_exp[r_addr[IW-1:0]];
        r_rd_hnd <= m_hnd[r_addr[IW-1:0]];
        r_rd_prm <= m_prm[r_addr[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtt_pkg::BS_IDLE;
            r_now       <= '0;
            r_idc       <= mtt_pkg::ID_RESERVED;
            r_vld       <= '0;
            r_rv        <= 1'b0;
            r_have      <= 1'b0;
            r_found     <= 1'b0;
            r_addr      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_idc       <= n_idc;
            r_vld       <= n_vld;
            r_rv        <= n_rv;
            r_have      <= n_have;
            r_found     <= n_found;
            r_addr      <= n_addr;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_ridx  <= n_ridx;
        r_best  <= n_best;
        r_blate <= n_blate;
        r_bid   <= n_bid;
        r_bexp  <= n_bexp;
        r_bhnd  <= n_bhnd;
        r_bprm  <= n_bprm;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

### rtl/mtt_chk.sv
module mtt_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input mtt_pkg::t_req i_req,
    input logic          o_rsp_valid,
    input mtt_pkg::t_rsp o_rsp
);

    a_no_rsp_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_rsp_valid)
        else $error("result shown right after reset");

    a_answer_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.kind != mtt_pkg::KIND_EXPIRY) |-> o_rsp.last)
        else $error("answer to a request is not marked last");

    a_query_only_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.kind != mtt_pkg::KIND_QUERY)
        |-> (!o_rsp.running && o_rsp.remaining_ms == 32'd0))
        else $error("query fields set on another result");

    a_full_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status == mtt_pkg::ST_FULL)
        |-> (o_rsp.result_id == mtt_pkg::ID_NONE && o_rsp.kind == mtt_pkg::KIND_START))
        else $error("table full answer is malformed");

    a_expiry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.kind == mtt_pkg::KIND_EXPIRY)
        |-> (o_rsp.status == mtt_pkg::ST_OK && o_rsp.result_id != mtt_pkg::ID_NONE
             && o_rsp.result_id != mtt_pkg::ID_RESERVED))
        else $error("expiry notice carries a bad identifier or status");

endmodule

bind multiplexed_timer_table mtt_chk u_mtt_chk (.*);
